FILE: sv/wcbl_pkg.sv
// ----------------------------------------------------------------------------
// wcbl_pkg: shared types and constants of the write credit bucket limiter
// Opcodes, time constants, the prescaler setup record and saturating refill.
// ----------------------------------------------------------------------------
package wcbl_pkg;

	// request opcodes
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_TICK   = 2'd1,
		OP_PRESET = 2'd2,
		OP_IDLE   = 2'd3
	} op_t;

	// seconds in one hour and its bit count
	localparam int          DIV_BITS     = 12;
	localparam logic [11:0] HOUR_SECONDS = 12'd3600;

	// allowance ceiling and low-water mark
	localparam logic [7:0] CREDIT_MAX = 8'd255;
	localparam logic [7:0] LOW_MARK   = 8'd64;

	// setup sequence: 18 steps cover both the hour divider and the hour split
	localparam int          STEP_W      = 5;
	localparam logic [4:0]  PREP_LAST   = 5'd17;
	localparam logic [11:0] RESET_PERIOD = 12'd3601;

	// prescaler setup derived from tick_seconds
	typedef struct packed {
		logic        busy;
		logic        acc_mode;   // tick of an hour or longer
		logic [11:0] period;     // prescaler reload, (3600 / secs) | 1
		logic [4:0]  hours;      // whole hours in one tick
		logic [11:0] rem_sec;    // leftover seconds in one tick
	} prep_t;

	// allowance plus refills, saturating at the ceiling
	function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [4:0] n);
		logic [8:0] sum;
		sum = {1'b0, a} + {4'd0, n};
		return (sum > {1'b0, CREDIT_MAX}) ? CREDIT_MAX : sum[7:0];
	endfunction

endpackage

FILE: sv/wcbl_in_if.sv
// ----------------------------------------------------------------------------
// wcbl_in_if: request channel
// Valid/ready channel carrying one limiter request per transaction.
// ----------------------------------------------------------------------------
interface wcbl_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [5:0] partition;
	logic [7:0] reload_cycles;
	logic [7:0] load_value;

	modport source (output valid, output op, output partition, output reload_cycles,
		output load_value, input ready);
	modport sink (input valid, input op, input partition, input reload_cycles,
		input load_value, output ready);
endinterface

FILE: sv/wcbl_out_if.sv
// ----------------------------------------------------------------------------
// wcbl_out_if: result channel
// Valid/ready channel carrying one limiter result per transaction.
// ----------------------------------------------------------------------------
interface wcbl_out_if;
	logic       valid;
	logic       ready;
	logic       granted;
	logic       status;
	logic [7:0] allowance;
	logic [7:0] budget_left;
	logic       allowance_low;

	modport source (output valid, output granted, output status, output allowance,
		output budget_left, output allowance_low, input ready);
	modport sink (input valid, input granted, input status, input allowance,
		input budget_left, input allowance_low, output ready);
endinterface

FILE: sv/write_credit_bucket_limiter.sv
// Pipeline: a request is registered in stage s1 and its result in stage s2.
// Throughput: one request per cycle, set by the single-pass bucket update,
// while rsp.ready holds. After a tick_seconds write, ready is low while the
// setup unit steps its divider; configuration writes are taken at any time.
// Reset: allowances and budgets clear, prescaler at one tick, tick_seconds
// behaves as 1 (period 3601 ticks), both pipeline stages empty.
// ----------------------------------------------------------------------------
// write_credit_bucket_limiter: two-level write credit limiter
// Buckets of partitions each hold an hourly allowance and a short budget;
// ticks are prescaled into hourly refills of every bucket.
// ----------------------------------------------------------------------------
module write_credit_bucket_limiter #(
	parameter int NUM_BUCKETS           = 8,
	parameter int PARTITIONS_PER_BUCKET = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	wcbl_in_if.sink     req,
	wcbl_out_if.source  rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

	// setup unit
	wcbl_pkg::prep_t prep;

	wcbl_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we),
		.secs   (cfg_wdata),
		.prep   (prep)
	);

	// state
	logic [7:0]  alw_q [NUM_BUCKETS];
	logic [7:0]  bud_q [NUM_BUCKETS];
	logic [11:0] tick_q;
	logic [11:0] acc_q;

	// pipeline registers
	logic              valid_s1;
	wcbl_pkg::op_t     op_s1;
	logic [5:0]        part_s1;
	logic [7:0]        reload_s1;
	logic [7:0]        load_s1;
	logic              valid_s2;
	logic              granted_s2;
	logic              status_s2;
	logic [7:0]        alw_s2;
	logic [7:0]        bud_s2;

	logic adv;
	logic take;
	logic fire;

	// handshake
	assign adv       = !valid_s2 || rsp.ready;
	assign fire      = valid_s1 && adv;
	assign req.ready = !prep.busy && !cfg_we && (!valid_s1 || adv);
	assign take      = req.valid && req.ready;

	// bucket of a partition, a constant table over all 64 partitions
	function automatic logic [BW-1:0] bucket_of(input logic [5:0] p);
		logic [BW-1:0] b;
		b = '0;
		for (int j = 0; j < 64; j++) begin
			if (p == 6'(j)) begin
				b = BW'((j / PARTITIONS_PER_BUCKET) % NUM_BUCKETS);
			end
		end
		return b;
	endfunction

	// bucket select
	logic [BW-1:0] b_idx;
	assign b_idx = bucket_of(part_s1);

	// prescaler and accumulator
	logic [11:0] cnt_dec;
	logic        period_end;
	logic [12:0] acc_sum;
	logic        acc_carry;
	logic [4:0]  refill_n;

	assign cnt_dec    = tick_q - 12'd1;
	assign period_end = (cnt_dec == 12'd0);
	assign acc_sum    = {1'b0, acc_q} + {1'b0, prep.rem_sec};
	assign acc_carry  = (acc_sum >= {1'b0, wcbl_pkg::HOUR_SECONDS});
	assign refill_n   = prep.acc_mode ? (prep.hours + {4'd0, acc_carry}) : 5'd1;

	// bucket update
	logic [7:0]  alw_nx [NUM_BUCKETS];
	logic [7:0]  bud_nx [NUM_BUCKETS];
	logic [11:0] tick_nx;
	logic [11:0] acc_nx;
	logic [7:0]  cur_a;
	logic [7:0]  cur_b;
	logic        granted;
	logic        status;

	assign cur_a = alw_q[b_idx];
	assign cur_b = bud_q[b_idx];

	always_comb begin
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			alw_nx[i] = alw_q[i];
			bud_nx[i] = bud_q[i];
		end
		tick_nx = tick_q;
		acc_nx  = acc_q;
		granted = 1'b1;
		status  = 1'b0;
		unique case (op_s1)
			wcbl_pkg::OP_WRITE: begin
				priority if (cur_b != 8'd0) begin
					bud_nx[b_idx] = cur_b - 8'd1;
				end else if (cur_a != 8'd0) begin
					bud_nx[b_idx] = reload_s1;
					alw_nx[b_idx] = cur_a - 8'd1;
				end else begin
					granted = 1'b0;
					status  = 1'b1;
				end
			end
			wcbl_pkg::OP_TICK: begin
				tick_nx = period_end ? prep.period : cnt_dec;
				if (period_end) begin
					for (int i = 0; i < NUM_BUCKETS; i++) begin
						alw_nx[i] = wcbl_pkg::sat_add(alw_q[i], refill_n);
					end
					if (prep.acc_mode) begin
						acc_nx = acc_carry ?
							12'(acc_sum - {1'b0, wcbl_pkg::HOUR_SECONDS}) : acc_sum[11:0];
					end
				end
			end
			wcbl_pkg::OP_PRESET: begin
				alw_nx[b_idx] = load_s1;
			end
			wcbl_pkg::OP_IDLE: begin
				granted = 1'b0;
			end
			default: begin
				granted = 1'b0;
			end
		endcase
	end

	// control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			tick_q   <= 12'd1;
			acc_q    <= '0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				alw_q[i] <= '0;
				bud_q[i] <= '0;
			end
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				tick_q <= tick_nx;
				acc_q  <= acc_nx;
				for (int i = 0; i < NUM_BUCKETS; i++) begin
					alw_q[i] <= alw_nx[i];
					bud_q[i] <= bud_nx[i];
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1     <= wcbl_pkg::op_t'(req.op);
			part_s1   <= req.partition;
			reload_s1 <= req.reload_cycles;
			load_s1   <= req.load_value;
		end
		if (fire) begin
			granted_s2 <= granted;
			status_s2  <= status;
			alw_s2     <= alw_nx[b_idx];
			bud_s2     <= bud_nx[b_idx];
		end
	end

	// result channel
	assign rsp.valid         = valid_s2;
	assign rsp.granted       = granted_s2;
	assign rsp.status        = status_s2;
	assign rsp.allowance     = alw_s2;
	assign rsp.budget_left   = bud_s2;
	assign rsp.allowance_low = (alw_s2 < wcbl_pkg::LOW_MARK);

`ifndef SYNTHESIS
	// no request is taken while the setup unit runs
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !prep.busy)
		else $error("request taken during prescaler setup");

	// a configuration write starts the setup unit
	a_cfg_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> prep.busy)
		else $error("setup not started after configuration write");

	// the prescaler never rests at zero
	a_tick_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q != 12'd0)
		else $error("prescaler count at zero");

	// leftover seconds stay below one hour
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q < wcbl_pkg::HOUR_SECONDS)
		else $error("seconds accumulator out of range");

	// a refused write is never marked granted
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 |-> !granted_s2)
		else $error("refused write marked granted");
`endif

endmodule

FILE: sv/wcbl_prep.sv
// ----------------------------------------------------------------------------
// wcbl_prep: prescaler setup unit
// After a tick_seconds write, works out the prescaler period (3600 / secs) | 1
// with a one-bit-per-cycle restoring divider, and splits secs into whole
// hours and leftover seconds by one compare-subtract per cycle.
// ----------------------------------------------------------------------------
module wcbl_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [15:0]     secs,
	output wcbl_pkg::prep_t prep
);

	logic [wcbl_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic [15:0]                 dvs_q;
	logic [15:0]                 div_rem_q;
	logic [11:0]                 quo_q;
	logic [15:0]                 hr_rem_q;
	logic [4:0]                  hr_cnt_q;
	wcbl_pkg::prep_t             out_q;

	logic [3:0]  bit_idx;
	logic [16:0] shifted;
	logic        div_ge;
	logic [15:0] div_rem_nx;
	logic [11:0] quo_nx;
	logic        div_on;
	logic        hr_ge;
	logic [15:0] hr_rem_nx;
	logic [4:0]  hr_cnt_nx;

	// restoring divider step on the constant 3600
	assign div_on     = (step_q < wcbl_pkg::STEP_W'(wcbl_pkg::DIV_BITS));
	assign bit_idx    = 4'(wcbl_pkg::DIV_BITS - 1) - step_q[3:0];
	assign shifted    = {div_rem_q, wcbl_pkg::HOUR_SECONDS[bit_idx]};
	assign div_ge     = (shifted >= {1'b0, dvs_q});
	assign div_rem_nx = div_ge ? 16'(shifted - {1'b0, dvs_q}) : shifted[15:0];
	assign quo_nx     = {quo_q[10:0], div_ge};

	// hour split step
	assign hr_ge     = (hr_rem_q >= {4'd0, wcbl_pkg::HOUR_SECONDS});
	assign hr_rem_nx = hr_ge ? (hr_rem_q - {4'd0, wcbl_pkg::HOUR_SECONDS}) : hr_rem_q;
	assign hr_cnt_nx = hr_ge ? (hr_cnt_q + 5'd1) : hr_cnt_q;

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q           <= 1'b0;
			step_q           <= '0;
			out_q.busy       <= 1'b0;
			out_q.acc_mode   <= 1'b0;
			out_q.period     <= wcbl_pkg::RESET_PERIOD;
			out_q.hours      <= '0;
			out_q.rem_sec    <= '0;
		end else if (start) begin
			busy_q     <= 1'b1;
			out_q.busy <= 1'b1;
			step_q     <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 5'd1;
			if (step_q == wcbl_pkg::PREP_LAST) begin
				busy_q         <= 1'b0;
				out_q.busy     <= 1'b0;
				out_q.acc_mode <= (dvs_q >= {4'd0, wcbl_pkg::HOUR_SECONDS});
				out_q.period   <= quo_q | 12'd1;
				out_q.hours    <= hr_cnt_nx;
				out_q.rem_sec  <= hr_rem_nx[11:0];
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			// a zero period counts as one second
			dvs_q     <= (secs == 16'd0) ? 16'd1 : secs;
			hr_rem_q  <= (secs == 16'd0) ? 16'd1 : secs;
			div_rem_q <= '0;
			quo_q     <= '0;
			hr_cnt_q  <= '0;
		end else if (busy_q) begin
			if (div_on) begin
				div_rem_q <= div_rem_nx;
				quo_q     <= quo_nx;
			end
			hr_rem_q <= hr_rem_nx;
			hr_cnt_q <= hr_cnt_nx;
		end
	end

	assign prep = out_q;

`ifndef SYNTHESIS
	// the partial remainder stays below the divisor
	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && div_on |-> div_rem_q < dvs_q)
		else $error("divider remainder not below divisor");

	// a finished setup leaves an odd period
	a_period_odd: assert property (@(posedge clk) disable iff (!arst_n)
		!out_q.busy |-> out_q.period[0])
		else $error("prescaler period even");

	// the leftover seconds stay below one hour
	a_rem_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		!out_q.busy |-> out_q.rem_sec < wcbl_pkg::HOUR_SECONDS)
		else $error("leftover seconds out of range");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the write credit bucket limiter
// Drives request transactions over the valid/ready channel, predicts every
// result from a local copy of the bucket state and prescaler, and compares
// each result transaction field by field. Phases step through several tick
// periods and several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned HOUR      = wcbl_pkg::HOUR_SECONDS;
	localparam int          QUIET_MAX = 2000;

	// one result transaction
	typedef struct packed {
		logic       granted;
		logic       status;
		logic [7:0] allowance;
		logic [7:0] budget_left;
		logic       allowance_low;
	} credit_result_t;

	// predicts bucket results and holds those not yet seen
	class credit_scoreboard;
		logic [7:0]     allow_mem [8];
		logic [7:0]     budget_mem [8];
		logic [15:0]    tick_cnt;
		int unsigned    sec_acc;
		logic [15:0]    tick_secs;
		credit_result_t pending [$];
		int             errors;

		function new();
			for (int i = 0; i < 8; i++) begin
				allow_mem[i]  = '0;
				budget_mem[i] = '0;
			end
			tick_cnt  = 16'd1;
			sec_acc   = 0;
			tick_secs = 16'd1;
			errors    = 0;
		endfunction

		function void set_tick_seconds(input logic [15:0] value);
			tick_secs = value;
		endfunction

		// one allowance unit to every bucket, saturating
		function void refill_buckets();
			for (int i = 0; i < 8; i++)
				if (allow_mem[i] < wcbl_pkg::CREDIT_MAX)
					allow_mem[i] = allow_mem[i] + 8'd1;
		endfunction

		// prescaler and hour accumulator
		function void advance_tick();
			int unsigned secs;
			secs = (tick_secs == 16'd0) ? 1 : int'(tick_secs);
			tick_cnt = tick_cnt - 16'd1;
			if (tick_cnt != 16'd0)
				return;
			tick_cnt = 16'((HOUR / secs) | 1);
			if (secs < HOUR)
				refill_buckets();
			else
				sec_acc = sec_acc + secs;
			while (sec_acc >= HOUR) begin
				sec_acc = sec_acc - HOUR;
				refill_buckets();
			end
			sec_acc = sec_acc & 32'h1FFFF;
		endfunction

		// accepted request: update state, queue the expected result
		function void note_request(input wcbl_pkg::op_t op, input logic [5:0] part,
				input logic [7:0] reload, input logic [7:0] load);
			logic [2:0]     b;
			credit_result_t res;
			b = part[5:3];
			res.granted = 1'b1;
			res.status  = 1'b0;
			case (op)
				wcbl_pkg::OP_WRITE: begin
					if (budget_mem[b] != 8'd0) begin
						budget_mem[b] = budget_mem[b] - 8'd1;
					end else if (allow_mem[b] != 8'd0) begin
						budget_mem[b] = reload;
						allow_mem[b]  = allow_mem[b] - 8'd1;
					end else begin
						res.granted = 1'b0;
						res.status  = 1'b1;
					end
				end
				wcbl_pkg::OP_TICK:   advance_tick();
				wcbl_pkg::OP_PRESET: allow_mem[b] = load;
				default:             res.granted = 1'b0;
			endcase
			res.allowance     = allow_mem[b];
			res.budget_left   = budget_mem[b];
			res.allowance_low = (allow_mem[b] < wcbl_pkg::LOW_MARK);
			pending.push_back(res);
		endfunction

		// accepted result against the oldest expectation
		function void check_result(input credit_result_t got);
			credit_result_t exp;
			if (pending.size() == 0) begin
				$error("result with nothing expected: %p", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.granted !== exp.granted) begin
				$error("granted: expected %0d, got %0d", exp.granted, got.granted);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				errors++;
			end
			if (got.allowance !== exp.allowance) begin
				$error("allowance: expected %0d, got %0d", exp.allowance, got.allowance);
				errors++;
			end
			if (got.budget_left !== exp.budget_left) begin
				$error("budget_left: expected %0d, got %0d", exp.budget_left,
					got.budget_left);
				errors++;
			end
			if (got.allowance_low !== exp.allowance_low) begin
				$error("allowance_low: expected %0d, got %0d", exp.allowance_low,
					got.allowance_low);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          idle_mode;    // 0 none, 1 sender, 2 receiver, 3 both
	bit          quiet;        // burst with no idling at all
	int          quiet_cycles;

	credit_scoreboard sb = new();

	wcbl_in_if  req_if ();
	wcbl_out_if rsp_if ();

	write_credit_bucket_limiter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// result side: check accepted transactions, stall at random
	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_result({rsp_if.granted, rsp_if.status, rsp_if.allowance,
				rsp_if.budget_left, rsp_if.allowance_low});
		if (quiet)
			rsp_if.ready <= 1'b1;
		else if (idle_mode == 2)
			rsp_if.ready <= !roll(87);
		else if (idle_mode == 3)
			rsp_if.ready <= !roll(29);
		else
			rsp_if.ready <= 1'b1;
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic bit sender_waits();
		if (quiet)
			return 1'b0;
		if (idle_mode == 1)
			return roll(87);
		if (idle_mode == 3)
			return roll(29);
		return 1'b0;
	endfunction

	// one request transaction, with idle cycles ahead of it
	task automatic send_request(input wcbl_pkg::op_t op, input logic [5:0] part,
			input logic [7:0] reload, input logic [7:0] load);
		while (sender_waits()) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.op            <= op;
		req_if.partition     <= part;
		req_if.reload_cycles <= reload;
		req_if.load_value    <= load;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(op, part, reload, load);
	endtask

	// tick period write, only once every result is back
	task automatic write_tick_seconds(input logic [15:0] value);
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_tick_seconds(value);
	endtask

	function automatic logic [7:0] pick_load();
		case ($urandom_range(9))
			0:       return 8'd0;
			1:       return 8'd1;
			2:       return 8'd63;
			3:       return 8'd64;
			4:       return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// random traffic, mostly writes against a few presets and ticks
	task automatic run_phase(input logic [15:0] secs, input int count, input int mode);
		int            r;
		wcbl_pkg::op_t op;
		logic [7:0]    reload;
		write_tick_seconds(secs);
		idle_mode = mode;
		for (int i = 0; i < count; i++) begin
			quiet = ((i / 32) % 4) == 3;
			r = $urandom_range(99);
			if (r < 55)
				op = wcbl_pkg::OP_WRITE;
			else if (r < 70)
				op = wcbl_pkg::OP_TICK;
			else if (r < 93)
				op = wcbl_pkg::OP_PRESET;
			else
				op = wcbl_pkg::OP_IDLE;
			reload = roll(60) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
			send_request(op, 6'($urandom_range(63)), reload, pick_load());
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		req_if.valid         = 1'b0;
		req_if.op            = wcbl_pkg::OP_WRITE;
		req_if.partition     = '0;
		req_if.reload_cycles = '0;
		req_if.load_value    = '0;
		rsp_if.ready         = 1'b0;
		idle_mode            = 0;
		quiet                = 1'b0;
		quiet_cycles         = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// largest tick first, so the prescaler never loads a long period early
		write_tick_seconds(16'd65535);

		// directed: refusal, unused op, preset extremes, reload, saturation
		send_request(wcbl_pkg::OP_WRITE,  6'd0,  8'd5,   8'd0);
		send_request(wcbl_pkg::OP_IDLE,   6'd63, 8'd255, 8'd255);
		send_request(wcbl_pkg::OP_PRESET, 6'd63, 8'd0,   8'd255);
		send_request(wcbl_pkg::OP_PRESET, 6'd8,  8'd0,   8'd0);
		send_request(wcbl_pkg::OP_PRESET, 6'd16, 8'd0,   8'd1);
		send_request(wcbl_pkg::OP_PRESET, 6'd24, 8'd0,   8'd63);
		send_request(wcbl_pkg::OP_PRESET, 6'd32, 8'd0,   8'd64);
		send_request(wcbl_pkg::OP_WRITE,  6'd16, 8'd255, 8'd0);
		send_request(wcbl_pkg::OP_WRITE,  6'd17, 8'd0,   8'd0);
		send_request(wcbl_pkg::OP_WRITE,  6'd24, 8'd0,   8'd0);
		send_request(wcbl_pkg::OP_WRITE,  6'd25, 8'd0,   8'd0);
		send_request(wcbl_pkg::OP_WRITE,  6'd8,  8'd1,   8'd0);
		send_request(wcbl_pkg::OP_TICK,   6'd63, 8'd0,   8'd0);
		send_request(wcbl_pkg::OP_TICK,   6'd8,  8'd0,   8'd0);
		send_request(wcbl_pkg::OP_WRITE,  6'd0,  8'd0,   8'd0);
		send_request(wcbl_pkg::OP_PRESET, 6'd40, 8'd0,   8'd255);
		send_request(wcbl_pkg::OP_WRITE,  6'd47, 8'd170, 8'd85);
		send_request(wcbl_pkg::OP_PRESET, 6'd55, 8'd85,  8'd0);
		send_request(wcbl_pkg::OP_WRITE,  6'd55, 8'd85,  8'd170);
		send_request(wcbl_pkg::OP_WRITE,  6'd42, 8'd255, 8'd255);
		send_request(wcbl_pkg::OP_IDLE,   6'd0,  8'd0,   8'd0);

		// exact hour, two hours, short period, hour plus, random long, then slow
		run_phase(16'd3600, 150, 1);
		run_phase(16'd7200, 150, 2);
		run_phase(16'd1799, 150, 3);
		run_phase(16'd4000, 150, 0);
		run_phase(16'($urandom_range(65535, 3600)), 150, 1);
		run_phase(16'd100,  150, 2);
		run_phase(16'd0,    150, 3);
		run_phase(16'd1,    150, 0);

		// drain
		req_if.valid <= 1'b0;
		idle_mode = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
